[design/gbepc_pkg.sv]
// ----------------------------------------------------------------------------
// gbepc_pkg
// Shared types, constants and modular helpers for the boundary-exit path
// counter: controller states, the per-cell command word and the modulus.
// ----------------------------------------------------------------------------
package gbepc_pkg;

   localparam int unsigned VAL_W = 30;
   localparam logic [VAL_W-1:0] EXIT_MODULUS = 30'd1000000007;

   typedef logic [VAL_W-1:0] value_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAYER,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // One cell update handed from the controller to the datapath
   typedef struct packed {
      logic issue;
      logic first_layer;
      logic wr_bank;
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
      logic is_start;
      logic clear_total;
   } cell_cmd_type;

   // Both operands below the modulus: one compare and subtract suffices
   function automatic value_type add_mod(value_type a, value_type b);
      logic [VAL_W:0] sum;
      logic [VAL_W:0] diff;
      sum  = {1'b0, a} + {1'b0, b};
      diff = sum - {1'b0, EXIT_MODULUS};
      return (sum >= {1'b0, EXIT_MODULUS}) ? diff[VAL_W-1:0] : sum[VAL_W-1:0];
   endfunction

endpackage

[design/grid_boundary_exit_path_counter.sv]
// ----------------------------------------------------------------------------
// grid_boundary_exit_path_counter
// Counts four-neighbour walks that leave a grid within a move limit,
// modulo 1000000007, one move layer at a time.
// ----------------------------------------------------------------------------
// Timing: one cell update a cycle through the layer stores, with a pipeline
// drain after each layer; an empty problem answers the cycle after transfer.
// Throughput: one problem at a time; start is taken the cycle after rsp_valid.
// Reset: synchronous, returns to idle with the total cleared; the layer
// stores need no clearing. rsp_valid is a one-cycle strobe, never held off.
// ----------------------------------------------------------------------------
module grid_boundary_exit_path_counter #(
   parameter int MAX_SIDE  = 64,
   parameter int MAX_MOVES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [6:0]  req_grid_rows,
   input  logic [6:0]  req_grid_cols,
   input  logic [6:0]  req_move_limit,
   input  logic [5:0]  req_start_row,
   input  logic [5:0]  req_start_col,
   output logic        rsp_valid,
   output logic [29:0] rsp_path_count
);

   import gbepc_pkg::*;

   localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   cell_cmd_type  cmd;
   logic [CW-1:0] cell_row, cell_col;
   logic          pipe_busy;
   value_type     path_count;

   gbepc_ctrl #(.MAX_SIDE(MAX_SIDE), .MAX_MOVES(MAX_MOVES)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_grid_rows  (req_grid_rows),
      .req_grid_cols  (req_grid_cols),
      .req_move_limit (req_move_limit),
      .req_start_row  (req_start_row),
      .req_start_col  (req_start_col),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd),
      .cell_row       (cell_row),
      .cell_col       (cell_col),
      .pipe_busy      (pipe_busy)
   );

   gbepc_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cell_row   (cell_row),
      .cell_col   (cell_col),
      .pipe_busy  (pipe_busy),
      .path_count (path_count)
   );

   assign rsp_path_count = path_count;

endmodule

[design/gbepc_layer_ram.sv]
// ----------------------------------------------------------------------------
// gbepc_layer_ram
// One copy of a layer store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gbepc_layer_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 30
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

[design/gbepc_datapath.sv]
// ----------------------------------------------------------------------------
// gbepc_datapath
// Ping-pong layer stores and a three-stage update pipeline: neighbour fetch,
// pairwise modular sums, final sum, then write-back and running total.
// ----------------------------------------------------------------------------
module gbepc_datapath #(
   parameter  int MAX_SIDE = 64,
   localparam int CW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gbepc_pkg::cell_cmd_type  cmd,
   input  logic [CW-1:0]            cell_row,
   input  logic [CW-1:0]            cell_col,
   output logic                     pipe_busy,
   output gbepc_pkg::value_type     path_count
);

   import gbepc_pkg::*;

   localparam int ADDR_W = 2 * CW;

   logic [ADDR_W-1:0] addr_up, addr_down, addr_left, addr_right, addr_cell;

   value_type rd_up    [2];
   value_type rd_down  [2];
   value_type rd_left  [2];
   value_type rd_right [2];

   // Stage 1: read data arrives with these
   logic              v1_ff;
   cell_cmd_type      cmd1_ff;
   logic [ADDR_W-1:0] addr1_ff;

   // Stage 2
   logic              v2_ff;
   value_type         pair_a_ff, pair_b_ff;
   logic [2:0]        miss_ff;
   logic              first2_ff, start2_ff, bank2_ff;
   logic [ADDR_W-1:0] addr2_ff;

   // Stage 3: write-back
   logic              v3_ff;
   value_type         val_ff;
   logic              start3_ff, bank3_ff;
   logic [ADDR_W-1:0] addr3_ff;

   value_type  total_ff, total_in;
   value_type  up_m, down_m, left_m, right_m;
   value_type  pair_a_in, pair_b_in, val_in;
   logic [2:0] miss_in;
   logic       rd_bank;

   // Out-of-grid neighbours wrap here; their data is masked off later
   assign addr_cell  = {cell_row, cell_col};
   assign addr_up    = {cell_row - CW'(1), cell_col};
   assign addr_down  = {cell_row + CW'(1), cell_col};
   assign addr_left  = {cell_row, cell_col - CW'(1)};
   assign addr_right = {cell_row, cell_col + CW'(1)};

   // Each bank holds two identical copies to give four reads a cycle
   for (genvar b = 0; b < 2; b++) begin : g_bank
      logic bank_wr;
      assign bank_wr = v3_ff && (bank3_ff == 1'(b));

      gbepc_layer_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_vert (
         .clock     (clock),
         .wr_en     (bank_wr),
         .wr_addr   (addr3_ff),
         .wr_data   (val_ff),
         .rd_addr_a (addr_up),
         .rd_addr_b (addr_down),
         .rd_data_a (rd_up[b]),
         .rd_data_b (rd_down[b])
      );

      gbepc_layer_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_horz (
         .clock     (clock),
         .wr_en     (bank_wr),
         .wr_addr   (addr3_ff),
         .wr_data   (val_ff),
         .rd_addr_a (addr_left),
         .rd_addr_b (addr_right),
         .rd_data_a (rd_left[b]),
         .rd_data_b (rd_right[b])
      );
   end

   always_comb begin
      rd_bank   = ~cmd1_ff.wr_bank;
      up_m      = cmd1_ff.has_up    ? rd_up[rd_bank]    : '0;
      down_m    = cmd1_ff.has_down  ? rd_down[rd_bank]  : '0;
      left_m    = cmd1_ff.has_left  ? rd_left[rd_bank]  : '0;
      right_m   = cmd1_ff.has_right ? rd_right[rd_bank] : '0;
      pair_a_in = add_mod(up_m, down_m);
      pair_b_in = add_mod(left_m, right_m);
      miss_in   = {2'b0, ~cmd1_ff.has_up} + {2'b0, ~cmd1_ff.has_down}
                + {2'b0, ~cmd1_ff.has_left} + {2'b0, ~cmd1_ff.has_right};
      val_in    = first2_ff ? VAL_W'(miss_ff) : add_mod(pair_a_ff, pair_b_ff);

      total_in = total_ff;
      if (cmd.clear_total) begin
         total_in = '0;
      end else if (v3_ff && start3_ff) begin
         total_in = add_mod(total_ff, val_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         total_ff <= '0;
      end else begin
         v1_ff    <= cmd.issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff   <= cmd;
      addr1_ff  <= addr_cell;

      pair_a_ff <= pair_a_in;
      pair_b_ff <= pair_b_in;
      miss_ff   <= miss_in;
      first2_ff <= cmd1_ff.first_layer;
      start2_ff <= cmd1_ff.is_start;
      bank2_ff  <= cmd1_ff.wr_bank;
      addr2_ff  <= addr1_ff;

      val_ff    <= val_in;
      start3_ff <= start2_ff;
      bank3_ff  <= bank2_ff;
      addr3_ff  <= addr2_ff;
   end

   assign pipe_busy  = v1_ff | v2_ff | v3_ff;
   assign path_count = total_ff;

endmodule

[design/gbepc_ctrl.sv]
// ----------------------------------------------------------------------------
// gbepc_ctrl
// Sequencer: captures a problem, walks every cell of every move layer in
// row-major order, drains the pipeline after each layer and strobes the result.
// ----------------------------------------------------------------------------
module gbepc_ctrl #(
   parameter  int MAX_SIDE  = 64,
   parameter  int MAX_MOVES = 64,
   localparam int CW        = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [6:0]               req_grid_rows,
   input  logic [6:0]               req_grid_cols,
   input  logic [6:0]               req_move_limit,
   input  logic [5:0]               req_start_row,
   input  logic [5:0]               req_start_col,
   output logic                     rsp_valid,
   output gbepc_pkg::cell_cmd_type  cmd,
   output logic [CW-1:0]            cell_row,
   output logic [CW-1:0]            cell_col,
   input  logic                     pipe_busy
);

   import gbepc_pkg::*;

   localparam int CNT_W = CW + 1;
   localparam int MV_W  = $clog2(MAX_MOVES + 1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    row_ff, row_in, col_ff, col_in;
   logic [MV_W-1:0]  layer_ff, layer_in;
   logic [CNT_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [MV_W-1:0]  moves_ff, moves_in;
   logic [CW-1:0]    srow_ff, srow_in, scol_ff, scol_in;

   logic [CNT_W-1:0] req_rows_c, req_cols_c;
   logic [MV_W-1:0]  req_moves_c;
   logic             accept, problem_ok, last_col, last_row;

   always_comb begin
      req_rows_c  = (32'(req_grid_rows) > MAX_SIDE) ? CNT_W'(MAX_SIDE)
                                                    : CNT_W'(req_grid_rows);
      req_cols_c  = (32'(req_grid_cols) > MAX_SIDE) ? CNT_W'(MAX_SIDE)
                                                    : CNT_W'(req_grid_cols);
      req_moves_c = (32'(req_move_limit) > MAX_MOVES) ? MV_W'(MAX_MOVES)
                                                      : MV_W'(req_move_limit);
      problem_ok  = (req_rows_c != '0) && (req_cols_c != '0) && (req_moves_c != '0)
                 && (32'(req_start_row) < 32'(req_rows_c))
                 && (32'(req_start_col) < 32'(req_cols_c));

      accept   = start && (state_ff == ST_IDLE);
      last_col = ({1'b0, col_ff} + CNT_W'(1)) == cols_ff;
      last_row = ({1'b0, row_ff} + CNT_W'(1)) == rows_ff;

      cmd             = '0;
      cmd.issue       = (state_ff == ST_LAYER);
      cmd.first_layer = (layer_ff == MV_W'(1));
      cmd.wr_bank     = layer_ff[0];
      cmd.has_up      = (row_ff != '0);
      cmd.has_down    = !last_row;
      cmd.has_left    = (col_ff != '0);
      cmd.has_right   = !last_col;
      cmd.is_start    = (row_ff == srow_ff) && (col_ff == scol_ff);
      cmd.clear_total = accept;

      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      layer_in = layer_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      moves_in = moves_ff;
      srow_in  = srow_ff;
      scol_in  = scol_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rows_in  = req_rows_c;
               cols_in  = req_cols_c;
               moves_in = req_moves_c;
               srow_in  = CW'(req_start_row);
               scol_in  = CW'(req_start_col);
               row_in   = '0;
               col_in   = '0;
               layer_in = MV_W'(1);
               state_in = problem_ok ? ST_LAYER : ST_DONE;
            end
         end
         ST_LAYER: begin
            // Advance row-major; leave the layer after its last cell
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  row_in   = '0;
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + CW'(1);
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            // Hold until the last write of this layer has landed
            if (!pipe_busy) begin
               if (layer_ff == moves_ff) begin
                  state_in = ST_DONE;
               end else begin
                  layer_in = layer_ff + MV_W'(1);
                  state_in = ST_LAYER;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         layer_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         layer_ff <= layer_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff  <= rows_in;
      cols_ff  <= cols_in;
      moves_ff <= moves_in;
      srow_ff  <= srow_in;
      scol_ff  <= scol_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign cell_row  = row_ff;
   assign cell_col  = col_ff;

endmodule

[design/gbepc_checker.sv]
// ----------------------------------------------------------------------------
// gbepc_checker
// Port-level checks on the command and result strobes of the path counter.
// ----------------------------------------------------------------------------
module gbepc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [29:0] rsp_path_count
);

   import gbepc_pkg::*;

   // A result belongs to a problem in flight
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while idle");

   // Exactly one cycle per result, then back to idle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe not a single cycle");

   // Transfer starts work
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("transfer did not start work");

   // Result is fully reduced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_path_count < EXIT_MODULUS))
      else $error("path count not reduced");

endmodule

bind grid_boundary_exit_path_counter gbepc_checker u_checker (.*);
